[rtl/ctid_pkg.sv]
// shared types and constants for the constant time integer divider
// used by ctid_ctrl, ctid_datapath and the top level; no dependencies

package ctid_pkg;

   // external field widths
   localparam int DATA_W = 64;
   localparam int CODE_W = 2;

   // width codes
   localparam logic [CODE_W-1:0] WIDTH_CODE_8  = 2'd0;
   localparam logic [CODE_W-1:0] WIDTH_CODE_16 = 2'd1;
   localparam logic [CODE_W-1:0] WIDTH_CODE_32 = 2'd2;
   localparam logic [CODE_W-1:0] WIDTH_CODE_64 = 2'd3;

   // division kinds
   localparam logic KIND_UNSIGNED = 1'b0;
   localparam logic KIND_SIGNED   = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;    // latch a new request
      logic prep;    // take magnitudes and align the dividend
      logic step;    // one restoring step
      logic finish;  // apply signs and load the result register
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic last;    // the step under way is the final one
   } status_type;

   // operand width in bits for a width code
   function automatic logic [6:0] code_to_width(input logic [CODE_W-1:0] code);
      logic [6:0] w;
      unique case (code)
         WIDTH_CODE_8:  w = 7'd8;
         WIDTH_CODE_16: w = 7'd16;
         WIDTH_CODE_32: w = 7'd32;
         WIDTH_CODE_64: w = 7'd64;
         default:       w = 7'd8;
      endcase
      return w;
   endfunction

endpackage

[rtl/constant_time_integer_divider_top.sv]
// constant time integer divider, restoring radix 2, one quotient bit per cycle
// request channel (req_): tdata carries the operands, tuser the kind, width and active flag
// result channel (rsp_): tdata carries quotient and remainder, held in an output register
// a request is taken only while the divider is idle and then occupies it until it has
// finished (w = 8, 16, 32 or 64 operand bits, capped at MAX_WIDTH): the accepting cycle
// latches it, a prep step forms magnitudes, w restoring steps run on the shared subtractor,
// and a sign step applies signs and loads the output register, which sets rsp_tvalid.
// no new request is accepted before the previous one has left its sign step.
// requests of one width take the same time whatever the data, unless held in the sign step.
// an inactive request divides by one; a zero divisor gives an all-ones magnitude quotient.
// while the receiver stalls, the finished result waits in the output register; should it
// still be waiting when the next request finishes, the divider holds in its sign step
// until the register drains.
// reset empties the result register and returns the sequencer to idle.
// depends on ctid_pkg, ctid_ctrl and ctid_datapath

module constant_time_integer_divider_top #(
   parameter int MAX_WIDTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // dividend [63:0], divisor [127:64]
   input  logic [3:0]   req_tuser,   // kind [0], width_code [2:1], active [3]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata    // quotient [63:0], remainder [127:64]
);

   ctid_pkg::cmd_type    cmd;
   ctid_pkg::status_type status;
   logic [ctid_pkg::DATA_W-1:0] quotient;
   logic [ctid_pkg::DATA_W-1:0] remainder;

   ctid_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   ctid_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .cmd           (cmd),
      .status        (status),
      .in_kind       (req_tuser[0]),
      .in_width_code (req_tuser[2:1]),
      .in_dividend   (req_tdata[63:0]),
      .in_divisor    (req_tdata[127:64]),
      .in_active     (req_tuser[3]),
      .out_quotient  (quotient),
      .out_remainder (remainder)
   );

   assign rsp_tdata = {remainder, quotient};

endmodule

[rtl/ctid_ctrl.sv]
// sequencer for the divider: accept, prepare, step loop, finish
// depends on ctid_pkg for the command and status structs

module ctid_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output ctid_pkg::cmd_type     cmd,
   input  ctid_pkg::status_type  status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_RUN,
      ST_FIX
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // the result slot is free when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd.load   = (state_ff == ST_IDLE) && req_tvalid;
      cmd.prep   = (state_ff == ST_PREP);
      cmd.step   = (state_ff == ST_RUN);
      cmd.finish = (state_ff == ST_FIX) && out_free;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (status.last) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/ctid_datapath.sv]
// operand registers, shared restoring subtractor, step counter and result register
// depends on ctid_pkg for command/status structs and width decoding

module ctid_datapath #(
   parameter int MAX_WIDTH = 64
) (
   input  logic                               clock,
   input  ctid_pkg::cmd_type                  cmd,
   output ctid_pkg::status_type               status,
   input  logic                               in_kind,
   input  logic [ctid_pkg::CODE_W-1:0]        in_width_code,
   input  logic [ctid_pkg::DATA_W-1:0]        in_dividend,
   input  logic [ctid_pkg::DATA_W-1:0]        in_divisor,
   input  logic                               in_active,
   output logic [ctid_pkg::DATA_W-1:0]        out_quotient,
   output logic [ctid_pkg::DATA_W-1:0]        out_remainder
);

   localparam int MW  = MAX_WIDTH;
   localparam int WCW = $clog2(MW + 1);
   localparam logic [6:0]     MAX_W7   = 7'(MW);
   localparam logic [WCW-1:0] MAX_WCNT = WCW'(MW);

   // operand state
   logic [MW-1:0]  a_ff, a_in;      // dividend, later shifted magnitude
   logic [MW-1:0]  b_ff, b_in;      // divisor, later magnitude
   logic [MW-1:0]  part_ff, part_in;
   logic [MW-1:0]  q_ff, q_in;
   logic [WCW-1:0] w_ff, w_in;
   logic [WCW-1:0] cnt_ff, cnt_in;
   logic           kind_ff, kind_in;
   logic           neg_q_ff, neg_q_in;
   logic           neg_r_ff, neg_r_in;
   logic [ctid_pkg::DATA_W-1:0] quot_ff, quot_in;
   logic [ctid_pkg::DATA_W-1:0] rem_ff, rem_in;

   // request decode
   logic [6:0]     w_full;
   logic [WCW-1:0] w_sel;
   logic [MW-1:0]  mask_new;
   logic [MW-1:0]  mask;
   logic [MW-1:0]  sign_mask;
   logic           a_neg, b_neg;
   logic [MW-1:0]  a_mag, b_mag;

   // restoring step
   logic [MW:0]    trial;
   logic           ge;
   logic [MW:0]    diff;

   // finish
   logic [MW-1:0]  q_fix, r_fix;

   assign w_full   = ctid_pkg::code_to_width(in_width_code);
   assign w_sel    = (w_full > MAX_W7) ? MAX_WCNT : WCW'(w_full);
   assign mask_new = ~({MW{1'b1}} << w_sel);

   assign mask      = ~({MW{1'b1}} << w_ff);
   assign sign_mask = {{(MW-1){1'b0}}, 1'b1} << (w_ff - 1'b1);
   assign a_neg     = kind_ff && ((a_ff & sign_mask) != '0);
   assign b_neg     = kind_ff && ((b_ff & sign_mask) != '0);
   assign a_mag     = a_neg ? ((-a_ff) & mask) : a_ff;
   assign b_mag     = b_neg ? ((-b_ff) & mask) : b_ff;

   // carry out of the shift sits in the top bit of the trial value
   assign trial = {part_ff, a_ff[MW-1]};
   assign ge    = (trial >= {1'b0, b_ff});
   assign diff  = trial - {1'b0, b_ff};

   assign q_fix = neg_q_ff ? ((-q_ff) & mask) : q_ff;
   assign r_fix = neg_r_ff ? ((-part_ff) & mask) : part_ff;

   assign status.last = (cnt_ff == WCW'(1));

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      part_in  = part_ff;
      q_in     = q_ff;
      w_in     = w_ff;
      cnt_in   = cnt_ff;
      kind_in  = kind_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      priority if (cmd.load) begin
         a_in    = in_dividend[MW-1:0] & mask_new;
         b_in    = in_active ? (in_divisor[MW-1:0] & mask_new) : MW'(1);
         w_in    = w_sel;
         kind_in = (in_kind == ctid_pkg::KIND_SIGNED);
      end else if (cmd.prep) begin
         // left-align the dividend so each step takes the top bit
         a_in     = a_mag << (MAX_WCNT - w_ff);
         b_in     = b_mag;
         part_in  = '0;
         q_in     = '0;
         cnt_in   = w_ff;
         neg_q_in = a_neg ^ b_neg;
         neg_r_in = a_neg;
      end else if (cmd.step) begin
         a_in    = a_ff << 1;
         part_in = ge ? diff[MW-1:0] : trial[MW-1:0];
         q_in    = {q_ff[MW-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
      end else if (cmd.finish) begin
         quot_in = ctid_pkg::DATA_W'(q_fix);
         rem_in  = ctid_pkg::DATA_W'(r_fix);
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      part_ff  <= part_in;
      q_ff     <= q_in;
      w_ff     <= w_in;
      cnt_ff   <= cnt_in;
      kind_ff  <= kind_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
   end

   assign out_quotient  = quot_ff;
   assign out_remainder = rem_ff;

endmodule

[verif/ctid_result_checker.sv]
`timescale 1ns / 1ps
// result checker for the constant time integer divider: watches both stream channels,
// predicts quotient and remainder per accepted request and compares them in order
// depends on ctid_pkg

module ctid_result_checker #(
   parameter int MAX_WIDTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [127:0] req_tdata,   // dividend [63:0], divisor [127:64]
   input  logic [3:0]   req_tuser,   // kind [0], width_code [2:1], active [3]
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,   // quotient [63:0], remainder [127:64]
   output int           fail_count,
   output int           awaited_count
);

   typedef struct packed {
      logic [ctid_pkg::DATA_W-1:0] quotient;
      logic [ctid_pkg::DATA_W-1:0] remainder;
   } quot_rem_type;

   quot_rem_type awaited_results[$];

   // one trial subtraction per bit; the extra top bit keeps the carry out of the shift
   function automatic logic [ctid_pkg::DATA_W-1:0] restore_divide(
      input logic [ctid_pkg::DATA_W-1:0] num,
      input logic [ctid_pkg::DATA_W-1:0] den,
      input int w);
      logic [ctid_pkg::DATA_W:0]   part;
      logic [ctid_pkg::DATA_W-1:0] q;
      int                          i;
      part = '0;
      q    = '0;
      for (i = w - 1; i >= 0; i--) begin
         part = {part[ctid_pkg::DATA_W-1:0], num[i]};
         if (part >= {1'b0, den}) begin
            part = part - {1'b0, den};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic quot_rem_type predict_division(
      input logic kind,
      input logic [ctid_pkg::CODE_W-1:0] width_code,
      input logic [ctid_pkg::DATA_W-1:0] dividend,
      input logic [ctid_pkg::DATA_W-1:0] divisor,
      input logic active);
      quot_rem_type                r;
      int                          w;
      logic [ctid_pkg::DATA_W-1:0] mask, sign_bit, a, b, am, bm, q;
      logic                        an, bn;
      case (width_code)
         ctid_pkg::WIDTH_CODE_8:  w = 8;
         ctid_pkg::WIDTH_CODE_16: w = 16;
         ctid_pkg::WIDTH_CODE_32: w = 32;
         default:                 w = 64;
      endcase
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      mask     = (w >= ctid_pkg::DATA_W) ? '1 : ((64'd1 << w) - 64'd1);
      sign_bit = 64'd1 << (w - 1);
      a = dividend & mask;
      b = active ? (divisor & mask) : 64'd1;
      if (kind == ctid_pkg::KIND_SIGNED) begin
         // divide magnitudes, then negate when exactly one operand is negative
         an = |(a & sign_bit);
         bn = |(b & sign_bit);
         am = an ? ((64'd0 - a) & mask) : a;
         bm = bn ? ((64'd0 - b) & mask) : b;
         q  = restore_divide(am, bm, w);
         if (an != bn) q = 64'd0 - q;
      end else begin
         q = restore_divide(a, b, w);
      end
      q = q & mask;
      r.quotient  = q;
      r.remainder = (a - q * b) & mask;
      return r;
   endfunction

   assign awaited_count = awaited_results.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      quot_rem_type want;
      quot_rem_type got;
      int           errs;
      errs = 0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            got.quotient  = rsp_tdata[63:0];
            got.remainder = rsp_tdata[127:64];
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result, quotient %h remainder %h",
                        $time, got.quotient, got.remainder);
               errs++;
            end else begin
               want = awaited_results.pop_front();
               if (got.quotient !== want.quotient) begin
                  $display("%0t: quotient mismatch, expected %h actual %h",
                           $time, want.quotient, got.quotient);
                  errs++;
               end
               if (got.remainder !== want.remainder) begin
                  $display("%0t: remainder mismatch, expected %h actual %h",
                           $time, want.remainder, got.remainder);
                  errs++;
               end
            end
         end
         if (req_tvalid && req_tready)
            awaited_results.push_back(predict_division(req_tuser[0], req_tuser[2:1],
                                                       req_tdata[63:0], req_tdata[127:64],
                                                       req_tuser[3]));
         if (errs != 0)
            fail_count <= fail_count + errs;
      end
   end

endmodule

[verif/tb_constant_time_integer_divider_top.sv]
`timescale 1ns / 1ps
// testbench top for the constant time integer divider: clock, reset, request stimulus
// and receiver stalls; checking is done by ctid_result_checker
// depends on ctid_pkg, ctid_result_checker and the divider rtl

module tb_constant_time_integer_divider_top;

   localparam int RANDOM_REQUESTS = 850;
   localparam int CALM_FROM       = 760;
   localparam int CYCLE_LIMIT     = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;    // dividend [63:0], divisor [127:64]
   logic [3:0]   req_tuser = '0;    // kind [0], width_code [2:1], active [3]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;         // quotient [63:0], remainder [127:64]

   int           fail_count;
   int           awaited_count;
   int           cycle_count = 0;
   bit           idling_on = 1'b1;

   constant_time_integer_divider_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ctid_result_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .awaited_count (awaited_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("constant_time_integer_divider_top test failed");
         $finish;
      end
   end

   // receiver stalls in short bursts while idling is on
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic issue_division(input logic kind,
                                 input logic [ctid_pkg::CODE_W-1:0] width_code,
                                 input logic [ctid_pkg::DATA_W-1:0] dividend,
                                 input logic [ctid_pkg::DATA_W-1:0] divisor,
                                 input logic active);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {divisor, dividend};
      req_tuser  <= {active, width_code, kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // random raw bits with the low operand bits often set to an edge value
   function automatic logic [ctid_pkg::DATA_W-1:0] pick_operand(
      input logic [ctid_pkg::CODE_W-1:0] width_code);
      logic [ctid_pkg::DATA_W-1:0] raw, mask, sign_bit, edge_val;
      case (width_code)
         ctid_pkg::WIDTH_CODE_8:  mask = 64'hff;
         ctid_pkg::WIDTH_CODE_16: mask = 64'hffff;
         ctid_pkg::WIDTH_CODE_32: mask = 64'hffff_ffff;
         default:                 mask = '1;
      endcase
      sign_bit = mask ^ (mask >> 1);
      raw      = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       edge_val = '0;
         1:       edge_val = 64'd1;
         2:       edge_val = '1;
         3:       edge_val = sign_bit;
         4:       edge_val = sign_bit - 64'd1;
         5:       edge_val = 64'($urandom_range(0, 15));
         6:       edge_val = -64'($urandom_range(1, 15));
         default: return raw;
      endcase
      return (raw & ~mask) | (edge_val & mask);
   endfunction

   initial begin
      int                          i;
      logic [ctid_pkg::CODE_W-1:0] code;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      issue_division(ctid_pkg::KIND_UNSIGNED, ctid_pkg::WIDTH_CODE_8, 64'hff, 64'h01, 1'b1);
      issue_division(ctid_pkg::KIND_UNSIGNED, ctid_pkg::WIDTH_CODE_8, 64'h00, 64'hff, 1'b1);
      issue_division(ctid_pkg::KIND_UNSIGNED, ctid_pkg::WIDTH_CODE_8, 64'h5a, 64'h00, 1'b1);
      // most negative over minus one wraps
      issue_division(ctid_pkg::KIND_SIGNED, ctid_pkg::WIDTH_CODE_8, 64'h80, 64'hff, 1'b1);
      issue_division(ctid_pkg::KIND_SIGNED, ctid_pkg::WIDTH_CODE_8, 64'h85, 64'h00, 1'b1);
      issue_division(ctid_pkg::KIND_SIGNED, ctid_pkg::WIDTH_CODE_8, 64'h05, 64'h00, 1'b1);
      issue_division(ctid_pkg::KIND_SIGNED, ctid_pkg::WIDTH_CODE_8, 64'h7f, 64'h80, 1'b1);
      // inactive requests divide by one
      issue_division(ctid_pkg::KIND_UNSIGNED, ctid_pkg::WIDTH_CODE_16, 64'h1234, 64'h0, 1'b0);
      issue_division(ctid_pkg::KIND_SIGNED, ctid_pkg::WIDTH_CODE_32, 64'h8000_0000, 64'h0,
                     1'b0);
      issue_division(ctid_pkg::KIND_SIGNED, ctid_pkg::WIDTH_CODE_64, 64'hdead_beef_0bad_f00d,
                     64'hffff_ffff_ffff_ffff, 1'b0);
      issue_division(ctid_pkg::KIND_SIGNED, ctid_pkg::WIDTH_CODE_16, 64'h8000, 64'hffff, 1'b1);
      issue_division(ctid_pkg::KIND_SIGNED, ctid_pkg::WIDTH_CODE_32, 64'h8000_0000,
                     64'hffff_ffff, 1'b1);
      issue_division(ctid_pkg::KIND_SIGNED, ctid_pkg::WIDTH_CODE_64, 64'h8000_0000_0000_0000,
                     '1, 1'b1);
      issue_division(ctid_pkg::KIND_UNSIGNED, ctid_pkg::WIDTH_CODE_64, '1, '1, 1'b1);
      // divisors with the top bit set at full width, and zero divisors
      issue_division(ctid_pkg::KIND_UNSIGNED, ctid_pkg::WIDTH_CODE_64, '1,
                     64'h8000_0000_0000_0001, 1'b1);
      issue_division(ctid_pkg::KIND_UNSIGNED, ctid_pkg::WIDTH_CODE_64, 64'hffff_ffff_ffff_fffe,
                     64'hc000_0000_0000_0000, 1'b1);
      issue_division(ctid_pkg::KIND_UNSIGNED, ctid_pkg::WIDTH_CODE_64, '1, 64'h0, 1'b1);
      issue_division(ctid_pkg::KIND_SIGNED, ctid_pkg::WIDTH_CODE_64, 64'hffff_ffff_ffff_fff9,
                     64'h0, 1'b1);
      // junk above the operand width must be ignored
      issue_division(ctid_pkg::KIND_UNSIGNED, ctid_pkg::WIDTH_CODE_16, 64'hffff_ffff_ffff_0064,
                     64'haaaa_aaaa_aaaa_0007, 1'b1);
      issue_division(ctid_pkg::KIND_SIGNED, ctid_pkg::WIDTH_CODE_32, 64'h5555_5555_ffff_fff9,
                     64'hffff_ffff_0000_0002, 1'b1);
      issue_division(ctid_pkg::KIND_UNSIGNED, ctid_pkg::WIDTH_CODE_32, 64'hffff_ffff, 64'h1,
                     1'b1);
      issue_division(ctid_pkg::KIND_SIGNED, ctid_pkg::WIDTH_CODE_64, 64'h7,
                     64'hffff_ffff_ffff_fffe, 1'b1);

      for (i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i == CALM_FROM) idling_on = 1'b0;
         code = ctid_pkg::CODE_W'($urandom_range(0, 3));
         issue_division(1'($urandom_range(0, 1)), code, pick_operand(code),
                        pick_operand(code), ($urandom_range(0, 7) != 0));
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (fail_count == 0 && awaited_count == 0) begin
         $display("constant_time_integer_divider_top test passed");
      end else begin
         $display("constant_time_integer_divider_top test failed");
      end
      $finish;
   end

endmodule

[constant_time_integer_divider_top.f]
rtl/ctid_pkg.sv
rtl/ctid_ctrl.sv
rtl/ctid_datapath.sv
rtl/constant_time_integer_divider_top.sv
verif/ctid_result_checker.sv
verif/tb_constant_time_integer_divider_top.sv
